FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the address decoder RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dad_pkg.sv
// Shared types and constants for the DRAM address decoder.
// No dependencies; used by every module of the decoder.
package dad_pkg;

  localparam int ADDR_W           = 64;
  localparam int GATHER_W         = 32;
  localparam int FIELD_W          = 4;
  localparam int GROUPS           = 6;
  localparam int CHUNK_W          = 8;
  localparam int CHUNKS           = ADDR_W / CHUNK_W;
  localparam int CHUNK_CNT_W      = $clog2(CHUNK_W + 1);
  localparam int OFFSET_W         = $clog2(ADDR_W + 1);
  localparam int COUNT_W          = 3;
  localparam int SLOT_W           = 4;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 64;
  localparam int MASK_ENTRIES_DEF = 16;
  localparam int MAX_GROUP_MASKS_DEF = 4;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_WRITE     = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROW_MASK   = 3'd0,
    CFG_COL_MASK   = 3'd1,
    CFG_CHANNEL    = 3'd2,
    CFG_SLOT       = 3'd3,
    CFG_SUBCHANNEL = 3'd4,
    CFG_RANK       = 3'd5,
    CFG_BANKGROUP  = 3'd6,
    CFG_BANK       = 3'd7
  } cfg_index_t;

  // Mask table write request, issued as a write beat leaves the first stage.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] word;
  } mask_wr_t;

endpackage

FILE: rtl/core/dad_mask_table.sv
// Hash mask table with per-entry parity against the stage A address.
// Depends on dad_pkg. Two register stages: byte parities, then entry parities.
module dad_mask_table #(
  parameter int MASK_ENTRIES = dad_pkg::MASK_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  dad_pkg::mask_wr_t          wr,
  input  logic [dad_pkg::ADDR_W-1:0] addr_a,
  output logic [MASK_ENTRIES-1:0]    parity_c
);

  logic [dad_pkg::ADDR_W-1:0]  table_r   [MASK_ENTRIES];
  logic [dad_pkg::CHUNKS-1:0]  bpar_r    [MASK_ENTRIES];
  logic [dad_pkg::CHUNKS-1:0]  bpar_nxt  [MASK_ENTRIES];
  logic [MASK_ENTRIES-1:0]     parity_r;
  logic [MASK_ENTRIES-1:0]     parity_nxt;

  always_comb begin
    for (int e = 0; e < MASK_ENTRIES; e++) begin
      for (int k = 0; k < dad_pkg::CHUNKS; k++) begin
        bpar_nxt[e][k] = ^(addr_a[k*dad_pkg::CHUNK_W +: dad_pkg::CHUNK_W] &
                           table_r[e][k*dad_pkg::CHUNK_W +: dad_pkg::CHUNK_W]);
      end
      parity_nxt[e] = ^bpar_r[e];
    end
  end

  // Slots at or past the table end match no entry, so such writes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < MASK_ENTRIES; e++) begin
        table_r[e] <= '0;
      end
    end else if (wr.we) begin
      for (int e = 0; e < MASK_ENTRIES; e++) begin
        if (32'(wr.slot) == e) begin
          table_r[e] <= wr.word;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bpar_r   <= bpar_nxt;
      parity_r <= parity_nxt;
    end
  end

  assign parity_c = parity_r;

endmodule

FILE: rtl/core/dad_bit_gather.sv
// Three-stage bit gather (pext) of the address under one select mask.
// Depends on dad_pkg. Chunk compress, chunk offsets, then shift and merge.
module dad_bit_gather (
  input  logic                         clk,
  input  logic                         en,
  input  logic [dad_pkg::ADDR_W-1:0]   addr_a,
  input  logic [dad_pkg::ADDR_W-1:0]   sel,
  output logic [dad_pkg::GATHER_W-1:0] result
);

  logic [dad_pkg::CHUNK_W-1:0]     pack_r    [dad_pkg::CHUNKS];
  logic [dad_pkg::CHUNK_W-1:0]     pack_nxt  [dad_pkg::CHUNKS];
  logic [dad_pkg::CHUNK_CNT_W-1:0] cnt_r     [dad_pkg::CHUNKS];
  logic [dad_pkg::CHUNK_CNT_W-1:0] cnt_nxt   [dad_pkg::CHUNKS];
  logic [dad_pkg::CHUNK_W-1:0]     pack_c_r  [dad_pkg::CHUNKS];
  logic [dad_pkg::OFFSET_W-1:0]    off_r     [dad_pkg::CHUNKS];
  logic [dad_pkg::OFFSET_W-1:0]    off_nxt   [dad_pkg::CHUNKS];
  logic [dad_pkg::GATHER_W-1:0]    result_r;
  logic [dad_pkg::GATHER_W-1:0]    result_nxt;

  // Stage B: compress each byte on its own.
  always_comb begin
    logic [dad_pkg::CHUNK_CNT_W-1:0] pos;
    for (int k = 0; k < dad_pkg::CHUNKS; k++) begin
      pos         = '0;
      pack_nxt[k] = '0;
      for (int j = 0; j < dad_pkg::CHUNK_W; j++) begin
        if (sel[k*dad_pkg::CHUNK_W + j]) begin
          pack_nxt[k][pos[dad_pkg::CHUNK_CNT_W-2:0]] = addr_a[k*dad_pkg::CHUNK_W + j];
          pos = pos + 1'b1;
        end
      end
      cnt_nxt[k] = pos;
    end
  end

  // Stage C: running bit offset of each packed byte.
  always_comb begin
    off_nxt[0] = '0;
    for (int k = 1; k < dad_pkg::CHUNKS; k++) begin
      off_nxt[k] = off_nxt[k-1] + dad_pkg::OFFSET_W'(cnt_r[k-1]);
    end
  end

  // Stage D: place each packed byte; bits beyond the result width drop.
  always_comb begin
    result_nxt = '0;
    for (int k = 0; k < dad_pkg::CHUNKS; k++) begin
      result_nxt = result_nxt |
                   (dad_pkg::GATHER_W'(pack_c_r[k]) << off_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pack_r   <= pack_nxt;
      cnt_r    <= cnt_nxt;
      pack_c_r <= pack_r;
      off_r    <= off_nxt;
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

FILE: rtl/core/dad_group_select.sv
// Picks each coordinate group's parity bits out of the entry parity vector.
// Depends on dad_pkg. Holds the output register of the group fields.
module dad_group_select #(
  parameter int MASK_ENTRIES    = dad_pkg::MASK_ENTRIES_DEF,
  parameter int MAX_GROUP_MASKS = dad_pkg::MAX_GROUP_MASKS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [MASK_ENTRIES-1:0]       parity_c,
  input  logic [dad_pkg::COUNT_W-1:0]   counts [dad_pkg::GROUPS],
  output logic [dad_pkg::FIELD_W-1:0]   group_val [dad_pkg::GROUPS]
);

  localparam int N_W   = $clog2(MAX_GROUP_MASKS + 1);
  localparam int SUM_W = $clog2(dad_pkg::GROUPS * MAX_GROUP_MASKS + dad_pkg::FIELD_W +
                                MASK_ENTRIES + 1);

  logic [dad_pkg::FIELD_W-1:0] val_r   [dad_pkg::GROUPS];
  logic [dad_pkg::FIELD_W-1:0] val_nxt [dad_pkg::GROUPS];

  always_comb begin
    logic [N_W-1:0]   n;
    logic [SUM_W-1:0] base;
    logic [SUM_W-1:0] idx;
    base = '0;
    for (int g = 0; g < dad_pkg::GROUPS; g++) begin
      // Clamp oversize counts to the group limit.
      if (32'(counts[g]) > MAX_GROUP_MASKS) begin
        n = N_W'(MAX_GROUP_MASKS);
      end else begin
        n = N_W'(counts[g]);
      end
      val_nxt[g] = '0;
      for (int i = 0; i < dad_pkg::FIELD_W; i++) begin
        idx = base + SUM_W'(i);
        if (32'(n) > i) begin
          // Indexes past the table end match nothing and read as zero.
          for (int e = 0; e < MASK_ENTRIES; e++) begin
            if (idx == SUM_W'(e)) begin
              val_nxt[g][i] = parity_c[e];
            end
          end
        end
      end
      base = base + SUM_W'(n);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
    end
  end

  assign group_val = val_r;

endmodule

FILE: rtl/core/dram_address_decoder_core.sv
// Top level of the DRAM address decoder: handshake, config and stage valids.
// Depends on dad_pkg, assert_macros.svh, dad_mask_table, dad_bit_gather,
// dad_group_select.
//
//  port group | dir | handshake            | payload
//  in_*       | in  | in_valid / in_stall  | op, phys_address, mask_slot, mask_word
//  out_*      | out | out_valid / out_stall| channel .. bank, row, column
//  cfg_*      | in  | cfg_we               | cfg_index, cfg_data
//
// One beat per cycle while in_stall is low; a translate result passes stages A,
// B, C and D into the output register. Mask writes update the table as they
// leave stage A and produce no beat.
// Reset clears valids, config registers and the mask table.
// A waiting result with out_stall high freezes every stage and raises in_stall.
`include "assert_macros.svh"

module dram_address_decoder_core #(
  parameter int MASK_ENTRIES    = dad_pkg::MASK_ENTRIES_DEF,
  parameter int MAX_GROUP_MASKS = dad_pkg::MAX_GROUP_MASKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic [dad_pkg::ADDR_W-1:0]      in_phys_address,
  input  logic [dad_pkg::SLOT_W-1:0]      in_mask_slot,
  input  logic [dad_pkg::ADDR_W-1:0]      in_mask_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dad_pkg::FIELD_W-1:0]     out_channel,
  output logic [dad_pkg::FIELD_W-1:0]     out_slot,
  output logic [dad_pkg::FIELD_W-1:0]     out_subchannel,
  output logic [dad_pkg::FIELD_W-1:0]     out_rank,
  output logic [dad_pkg::FIELD_W-1:0]     out_bank_group,
  output logic [dad_pkg::FIELD_W-1:0]     out_bank,
  output logic [dad_pkg::GATHER_W-1:0]    out_row,
  output logic [dad_pkg::GATHER_W-1:0]    out_column,
  input  logic                            cfg_we,
  input  logic [dad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dad_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                         en;
  logic                         va_r, vb_r, vc_r, vd_r;
  dad_pkg::op_t                 op_r;
  logic [dad_pkg::ADDR_W-1:0]   addr_r;
  logic [dad_pkg::SLOT_W-1:0]   slot_r;
  logic [dad_pkg::ADDR_W-1:0]   word_r;
  logic [dad_pkg::ADDR_W-1:0]   row_mask_r;
  logic [dad_pkg::ADDR_W-1:0]   col_mask_r;
  logic [dad_pkg::COUNT_W-1:0]  count_r [dad_pkg::GROUPS];
  dad_pkg::mask_wr_t            mask_wr;
  logic [MASK_ENTRIES-1:0]      parity_c;
  logic [dad_pkg::FIELD_W-1:0]  group_val [dad_pkg::GROUPS];

  // Freeze the whole pipe only while a finished beat waits downstream.
  assign in_stall = vd_r && out_stall;
  assign en       = !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r && (op_r == dad_pkg::OP_TRANSLATE);
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      op_r   <= dad_pkg::op_t'(in_op);
      addr_r <= in_phys_address;
      slot_r <= in_mask_slot;
      word_r <= in_mask_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_mask_r <= '0;
      col_mask_r <= '0;
      for (int g = 0; g < dad_pkg::GROUPS; g++) begin
        count_r[g] <= '0;
      end
    end else if (cfg_we) begin
      unique case (dad_pkg::cfg_index_t'(cfg_index))
        dad_pkg::CFG_ROW_MASK:   row_mask_r <= cfg_data;
        dad_pkg::CFG_COL_MASK:   col_mask_r <= cfg_data;
        dad_pkg::CFG_CHANNEL:    count_r[0] <= cfg_data[dad_pkg::COUNT_W-1:0];
        dad_pkg::CFG_SLOT:       count_r[1] <= cfg_data[dad_pkg::COUNT_W-1:0];
        dad_pkg::CFG_SUBCHANNEL: count_r[2] <= cfg_data[dad_pkg::COUNT_W-1:0];
        dad_pkg::CFG_RANK:       count_r[3] <= cfg_data[dad_pkg::COUNT_W-1:0];
        dad_pkg::CFG_BANKGROUP:  count_r[4] <= cfg_data[dad_pkg::COUNT_W-1:0];
        dad_pkg::CFG_BANK:       count_r[5] <= cfg_data[dad_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Commit a mask write as it leaves stage A, behind every earlier translate.
  assign mask_wr.we   = va_r && (op_r == dad_pkg::OP_WRITE) && en;
  assign mask_wr.slot = slot_r;
  assign mask_wr.word = word_r;

  dad_mask_table #(
    .MASK_ENTRIES (MASK_ENTRIES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .wr       (mask_wr),
    .addr_a   (addr_r),
    .parity_c (parity_c)
  );

  dad_group_select #(
    .MASK_ENTRIES    (MASK_ENTRIES),
    .MAX_GROUP_MASKS (MAX_GROUP_MASKS)
  ) u_groups (
    .clk       (clk),
    .en        (en),
    .parity_c  (parity_c),
    .counts    (count_r),
    .group_val (group_val)
  );

  dad_bit_gather u_row (
    .clk    (clk),
    .en     (en),
    .addr_a (addr_r),
    .sel    (row_mask_r),
    .result (out_row)
  );

  dad_bit_gather u_col (
    .clk    (clk),
    .en     (en),
    .addr_a (addr_r),
    .sel    (col_mask_r),
    .result (out_column)
  );

  assign out_valid      = vd_r;
  assign out_channel    = group_val[0];
  assign out_slot       = group_val[1];
  assign out_subchannel = group_val[2];
  assign out_rank       = group_val[3];
  assign out_bank_group = group_val[4];
  assign out_bank       = group_val[5];

  `DAD_ASSERT_NXT(a_write_no_beat, clk, rst_n, va_r && (op_r == dad_pkg::OP_WRITE) && en, !vb_r, "mask write entered stage B")
  `DAD_ASSERT_NXT(a_stall_holds_b, clk, rst_n, vb_r && !en, vb_r, "stage B beat lost under stall")
  `DAD_ASSERT_IMP(a_out_from_c, clk, rst_n, $rose(vd_r), $past(vc_r), "result without stage C beat")

endmodule
